@@ design/sstm_pkg.sv @@
`timescale 1ns / 1ps
// Package for the sorted signature table match unit.
// Holds default sizes, request and status codes and the sequencer state type.
// No dependencies.
package sstm_pkg;

  localparam int NUM_ENTRIES_DEF   = 16;
  localparam int MAX_SIG_BYTES_DEF = 16;
  localparam int MAX_SIG_SPAN_DEF  = 256;

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_SIG    = 2'd1;
  localparam logic [1:0] REQ_HEADER = 2'd2;

  localparam logic [1:0] INS_OK      = 2'd0;
  localparam logic [1:0] INS_BAD_LEN = 2'd1;
  localparam logic [1:0] INS_RANGE   = 2'd2;
  localparam logic [1:0] INS_FULL    = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK,
    ST_ADDR,
    ST_META,
    ST_RD,
    ST_CMP,
    ST_INS,
    ST_OUT
  } state_t;

endpackage

@@ design/sstm_order_list.sv @@
`timescale 1ns / 1ps
// Sorted order list: physical slot number for each sorted position.
// Insert shifts the tail up by one. Depends on sstm_pkg.
module sstm_order_list
  import sstm_pkg::*;
#(
  parameter int NUM_ENTRIES = NUM_ENTRIES_DEF,
  parameter int IW          = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1
) (
  input  logic          clk,
  input  logic          ins_en,
  input  logic [IW-1:0] ins_pos,
  input  logic [IW-1:0] ins_val,
  input  logic [IW-1:0] rd_idx,
  output logic [IW-1:0] rd_val
);

  logic [IW-1:0] order [NUM_ENTRIES];

  always_ff @(posedge clk) begin
    if (ins_en) begin
      for (int k = 0; k < NUM_ENTRIES; k++) begin
        if (IW'(k) == ins_pos) begin
          order[k] <= ins_val;
        end else if (k > 0 && IW'(k) > ins_pos) begin
          order[k] <= order[k-1];
        end
      end
    end
  end

  assign rd_val = order[rd_idx];

endmodule

@@ design/sorted_signature_table_match_unit.sv @@
`timescale 1ns / 1ps
// Sorted signature table match unit, top level. Depends on sstm_pkg, sstm_order_list.
// Clear and non-final bytes are taken while idle. A final signature byte is checked,
// then walks the sorted entries (slot address, descriptor, a read and a compare per
// byte) and is inserted; a rejected one goes straight to the result. A final header
// byte walks likewise. A single byte comparator is shared; a held result stalls.
// Reset clears counts and the sequencer; stores need no clearing pass.
module sorted_signature_table_match_unit
  import sstm_pkg::*;
#(
  parameter int NUM_ENTRIES   = NUM_ENTRIES_DEF,
  parameter int MAX_SIG_BYTES = MAX_SIG_BYTES_DEF,
  parameter int MAX_SIG_SPAN  = MAX_SIG_SPAN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] req_type,
  input  logic [7:0] data_byte,
  input  logic [8:0] base_offset,
  input  logic [7:0] ext_id,
  input  logic       last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       result_kind,
  output logic [1:0] insert_status,
  output logic       matched,
  output logic [7:0] match_ext,
  output logic [3:0] match_slot
);

  localparam int CW  = $clog2(NUM_ENTRIES + 1);
  localparam int IW  = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int LW  = $clog2(MAX_SIG_BYTES + 2);
  localparam int EAW = (NUM_ENTRIES * MAX_SIG_BYTES > 1) ?
                       $clog2(NUM_ENTRIES * MAX_SIG_BYTES) : 1;
  localparam int HW  = $clog2(MAX_SIG_SPAN + 1);
  localparam int HAW = (MAX_SIG_SPAN > 1) ? $clog2(MAX_SIG_SPAN) : 1;
  localparam int SW  = $clog2(512 + MAX_SIG_SPAN + MAX_SIG_BYTES) + 1;

  state_t state, state_next;

  logic [CW-1:0] count;
  logic [LW-1:0] slen;
  logic [HW-1:0] hlen;
  logic          mode;
  logic [8:0]    off_q;
  logic [7:0]    ext_q;
  logic [LW-1:0] len_q;
  logic [CW-1:0] idx;
  logic [LW-1:0] bi;
  logic [LW-1:0] n_q;
  logic [IW-1:0] phys;
  logic [1:0]    status_q;
  logic          found;

  logic [7:0]    ebytes [NUM_ENTRIES * MAX_SIG_BYTES];
  logic [7:0]    hdr    [MAX_SIG_SPAN];
  logic [8:0]    m_off_mem [NUM_ENTRIES];
  logic [LW-1:0] m_len_mem [NUM_ENTRIES];
  logic [7:0]    m_ext_mem [NUM_ENTRIES];

  logic [8:0]    m_off;
  logic [LW-1:0] m_len;
  logic [7:0]    m_ext;
  logic [7:0]    ea_q, eb_q, hd_q;

  logic          acc;
  logic [IW-1:0] order_rd;
  logic          ins_en;
  logic [LW-1:0] slen_upd;
  logic [7:0]    cmp_a;
  logic          bytes_ne, a_lt_b, last_byte, meta_far, chk_fail;
  logic [1:0]    chk_status;

  assign acc = in_valid && in_ready;
  assign slen_upd = (slen < LW'(MAX_SIG_BYTES)) ? slen + LW'(1) : LW'(MAX_SIG_BYTES + 1);
  assign cmp_a = mode ? hd_q : ea_q;
  assign bytes_ne = cmp_a != eb_q;
  assign a_lt_b = cmp_a < eb_q;
  assign last_byte = (bi + LW'(1)) == n_q;
  assign meta_far = (SW'(m_off) + SW'(m_len)) > SW'(hlen);

  always_comb begin
    chk_fail = 1'b1;
    chk_status = INS_OK;
    if (SW'(off_q) > SW'(MAX_SIG_SPAN)) begin
      chk_status = INS_RANGE;
    end else if (len_q == '0 || len_q > LW'(MAX_SIG_BYTES)) begin
      chk_status = INS_BAD_LEN;
    end else if ((SW'(off_q) + SW'(len_q)) > SW'(MAX_SIG_SPAN)) begin
      chk_status = INS_RANGE;
    end else if (count >= CW'(NUM_ENTRIES)) begin
      chk_status = INS_FULL;
    end else begin
      chk_fail = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (acc && last && req_type == REQ_SIG) begin
          state_next = ST_CHK;
        end else if (acc && last && req_type == REQ_HEADER) begin
          state_next = ST_ADDR;
        end
      end
      ST_CHK:  state_next = chk_fail ? ST_OUT : ST_ADDR;
      ST_ADDR: begin
        if (idx == count) begin
          state_next = mode ? ST_OUT : ST_INS;
        end else begin
          state_next = ST_META;
        end
      end
      ST_META: begin
        if (mode) begin
          state_next = meta_far ? ST_ADDR : ST_RD;
        end else if (off_q != m_off) begin
          state_next = (off_q < m_off) ? ST_INS : ST_ADDR;
        end else begin
          state_next = ST_RD;
        end
      end
      ST_RD:   state_next = ST_CMP;
      ST_CMP: begin
        if (bytes_ne) begin
          state_next = (!mode && a_lt_b) ? ST_INS : ST_ADDR;
        end else if (last_byte) begin
          if (mode) begin
            state_next = ST_OUT;
          end else begin
            state_next = (len_q <= m_len) ? ST_ADDR : ST_INS;
          end
        end else begin
          state_next = ST_RD;
        end
      end
      ST_INS:  state_next = ST_OUT;
      ST_OUT:  state_next = (!out_valid || out_ready) ? ST_IDLE : ST_OUT;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    ins_en = 1'b0;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_INS:  ins_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control counters and sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      slen <= '0;
      hlen <= '0;
      mode <= 1'b0;
      idx <= '0;
      bi <= '0;
      found <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_OUT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          idx <= '0;
          found <= 1'b0;
          if (acc) begin
            case (req_type)
              REQ_CLEAR: begin
                count <= '0;
                slen <= '0;
              end
              REQ_SIG: begin
                slen <= last ? '0 : slen_upd;
                mode <= 1'b0;
              end
              REQ_HEADER: begin
                if (hlen < HW'(MAX_SIG_SPAN)) begin
                  hlen <= hlen + HW'(1);
                end
                mode <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        ST_META: begin
          bi <= '0;
          if (mode && meta_far) begin
            idx <= idx + CW'(1);
          end else if (!mode && off_q > m_off) begin
            idx <= idx + CW'(1);
          end
        end
        ST_CMP: begin
          if (bytes_ne) begin
            if (mode || !a_lt_b) begin
              idx <= idx + CW'(1);
            end
          end else if (last_byte) begin
            if (mode) begin
              found <= 1'b1;
            end else if (len_q <= m_len) begin
              idx <= idx + CW'(1);
            end
          end else begin
            bi <= bi + LW'(1);
          end
        end
        ST_INS: count <= count + CW'(1);
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            hlen <= mode ? '0 : hlen;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && acc && req_type == REQ_SIG && last) begin
      off_q <= base_offset;
      ext_q <= ext_id;
      len_q <= slen_upd;
    end
    if (state == ST_CHK) begin
      status_q <= chk_status;
    end
    if (state == ST_INS) begin
      status_q <= INS_OK;
    end
    if (state == ST_ADDR) begin
      phys <= order_rd;
    end
    if (state == ST_META) begin
      n_q <= (mode || len_q > m_len) ? m_len : len_q;
    end
    if (state == ST_OUT && (!out_valid || out_ready)) begin
      result_kind <= mode;
      insert_status <= mode ? INS_OK : status_q;
      matched <= found;
      match_ext <= found ? m_ext : 8'd0;
      match_slot <= found ? 4'(idx) : 4'd0;
    end
  end

  // signature byte store
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && acc && req_type == REQ_SIG &&
        slen < LW'(MAX_SIG_BYTES) && count < CW'(NUM_ENTRIES)) begin
      ebytes[EAW'(count) * EAW'(MAX_SIG_BYTES) + EAW'(slen)] <= data_byte;
    end
    if (state == ST_RD) begin
      ea_q <= ebytes[EAW'(count) * EAW'(MAX_SIG_BYTES) + EAW'(bi)];
      eb_q <= ebytes[EAW'(phys) * EAW'(MAX_SIG_BYTES) + EAW'(bi)];
    end
  end

  // header store
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && acc && req_type == REQ_HEADER &&
        hlen < HW'(MAX_SIG_SPAN)) begin
      hdr[HAW'(hlen)] <= data_byte;
    end
    if (state == ST_RD) begin
      hd_q <= hdr[HAW'(SW'(m_off) + SW'(bi))];
    end
  end

  // entry descriptors, by physical slot
  always_ff @(posedge clk) begin
    if (ins_en) begin
      m_off_mem[IW'(count)] <= off_q;
      m_len_mem[IW'(count)] <= len_q;
      m_ext_mem[IW'(count)] <= ext_q;
    end
    if (state == ST_ADDR) begin
      m_off <= m_off_mem[order_rd];
      m_len <= m_len_mem[order_rd];
      m_ext <= m_ext_mem[order_rd];
    end
  end

  sstm_order_list #(
    .NUM_ENTRIES(NUM_ENTRIES),
    .IW         (IW)
  ) u_order (
    .clk    (clk),
    .ins_en (ins_en),
    .ins_pos(IW'(idx)),
    .ins_val(IW'(count)),
    .rd_idx (IW'(idx)),
    .rd_val (order_rd)
  );

`ifndef ASSERT_OFF
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(NUM_ENTRIES)) else $error("entry count overflow");
  a_ins_step: assert property (@(posedge clk) disable iff (rst)
    state == ST_INS |=> count == $past(count) + CW'(1)) else $error("insert did not count");
  a_slen_max: assert property (@(posedge clk) disable iff (rst)
    slen <= LW'(MAX_SIG_BYTES + 1)) else $error("staging length overflow");
  a_hlen_max: assert property (@(posedge clk) disable iff (rst)
    hlen <= HW'(MAX_SIG_SPAN)) else $error("header length overflow");
  a_ins_room: assert property (@(posedge clk) disable iff (rst)
    state == ST_INS |-> count < CW'(NUM_ENTRIES)) else $error("insert into full table");
`endif

endmodule
